/* hw/rtl/ttl_pkg.sv */
// Package for the TTL key-value table: operation and status codes, slot record,
// sequencer states and the scan status bundle.
// No dependencies.
`default_nettype none

package ttl_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;
   localparam int TIME_W          = 32;
   localparam int LIFE_W          = 24;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_ERASE = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [TIME_W-1:0]  expiry;
   } slot_type;

   typedef struct packed {
      logic stop;
      logic hit;
      logic hit_live;
      logic free;
   } scan_status_type;

endpackage

`default_nettype wire

/* hw/rtl/ttl_slot_mem.sv */
// Slot storage: one write port, one registered read port.
// Depends on ttl_pkg.
`default_nettype none

module ttl_slot_mem #(
   parameter int DEPTH = ttl_pkg::ENTRIES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire  [AW-1:0]           wr_addr,
   input  wire  ttl_pkg::slot_type wr_data,
   input  wire  [AW-1:0]           rd_addr,
   output ttl_pkg::slot_type       rd_data
);
   import ttl_pkg::*;

   slot_type mem_ff [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/ttl_scan_unit.sv */
// Shared slot comparator: checks one slot per cycle against the key and the
// clock, and tracks the first key match and the lowest free or expired slot.
// Depends on ttl_pkg.
`default_nettype none

module ttl_scan_unit #(
   parameter int DEPTH = ttl_pkg::ENTRIES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire                          chk_valid,
   input  wire  [AW-1:0]                chk_idx,
   input  wire  ttl_pkg::slot_type      slot,
   input  wire  [ttl_pkg::KEY_W-1:0]    lookup_key,
   input  wire  [ttl_pkg::TIME_W-1:0]   time_now,
   output ttl_pkg::scan_status_type     scan_status,
   output logic [AW-1:0]                hit_idx,
   output logic [AW-1:0]                free_idx,
   output logic [ttl_pkg::VALUE_W-1:0]  hit_value
);
   import ttl_pkg::*;

   logic               hit_ff, hit_in;
   logic               live_ff, live_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic               expired;
   logic               match;
   logic               is_free;

   assign expired = time_now > slot.expiry;
   assign match   = chk_valid && slot.valid && (slot.key == lookup_key);
   assign is_free = chk_valid && (!slot.valid || expired);

   always_comb begin
      hit_in      = hit_ff;
      live_in     = live_ff;
      value_in    = value_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            live_in    = !expired;
            value_in   = slot.value;
            hit_idx_in = chk_idx;
         end
         if (is_free && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
      live_ff     <= live_in;
      value_ff    <= value_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign scan_status.stop     = match || (chk_valid && (chk_idx == AW'(DEPTH - 1)));
   assign scan_status.hit      = hit_ff;
   assign scan_status.hit_live = live_ff;
   assign scan_status.free     = free_ff;
   assign hit_idx              = hit_idx_ff;
   assign free_idx             = free_idx_ff;
   assign hit_value            = value_ff;

endmodule

`default_nettype wire

/* hw/rtl/ttl_key_value_table.sv */
// Bounded key-value table with per-entry expiry. Each request beat is a put,
// get, erase or tick and yields one response beat. Put, get and erase scan the
// slot memory one slot per cycle through a single comparator, since the slot
// memory has one read port, stopping at a key match. Tick skips the scan. After
// reset a clearing pass invalidates every slot; req_ready stays low meanwhile.
// Depends on ttl_pkg, ttl_slot_mem, ttl_scan_unit.
`default_nettype none

module ttl_key_value_table #(
   parameter int ENTRIES = ttl_pkg::ENTRIES_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  [1:0]          req_operation,
   input  wire  [31:0]         req_lookup_key,
   input  wire  signed [31:0]  req_store_value,
   input  wire  [23:0]         req_lifetime,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_read_value
);
   import ttl_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [LIFE_W-1:0]  life_ff;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic               issue_done_ff, issue_done_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [AW-1:0]      chk_idx_ff, chk_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic               accept;
   logic               start;
   logic               rsp_free;
   logic               last_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   slot_type           mem_wdata;
   slot_type           mem_rdata;
   scan_status_type    scan_status;
   logic [AW-1:0]      hit_idx;
   logic [AW-1:0]      free_idx;
   logic [VALUE_W-1:0] hit_value;
   logic [TIME_W:0]    exp_sum;
   logic [TIME_W-1:0]  exp_time;

   assign accept    = req_valid && req_ready;
   assign start     = accept;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_addr = rd_addr_ff == AW'(ENTRIES - 1);
   assign exp_sum   = {1'b0, time_ff} + {{(TIME_W + 1 - LIFE_W){1'b0}}, life_ff};
   assign exp_time  = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

   ttl_slot_mem #(
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rdata)
   );

   ttl_scan_unit #(
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .chk_valid   (chk_valid_ff),
      .chk_idx     (chk_idx_ff),
      .slot        (mem_rdata),
      .lookup_key  (key_ff),
      .time_now    (time_ff),
      .scan_status (scan_status),
      .hit_idx     (hit_idx),
      .free_idx    (free_idx),
      .hit_value   (hit_value)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (last_addr) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (op_type'(req_operation) == OP_TICK) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_status.stop) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = state_ff == ST_IDLE;
      rd_addr_in    = rd_addr_ff;
      issue_done_in = issue_done_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = rd_addr_ff;
      time_in       = time_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_addr_ff;
      mem_wdata     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      // the finish step may repeat while the response slot is busy; its write is idempotent
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            rd_addr_in = rd_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            rd_addr_in    = '0;
            issue_done_in = 1'b0;
            if (accept && op_type'(req_operation) == OP_TICK && time_ff != {TIME_W{1'b1}}) begin
               time_in = time_ff + TIME_W'(1);
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               chk_valid_in  = 1'b1;
               rd_addr_in    = rd_addr_ff + AW'(1);
               issue_done_in = last_addr;
            end
         end
         ST_FINISH: begin
            rsp_status_in = STAT_OK;
            rsp_value_in  = '0;
            unique case (op_ff)
               OP_PUT: begin
                  mem_we       = scan_status.hit || scan_status.free;
                  mem_waddr    = scan_status.hit ? hit_idx : free_idx;
                  mem_wdata    = '{valid: 1'b1, key: key_ff, value: value_ff, expiry: exp_time};
                  if (!mem_we) rsp_status_in = STAT_FULL;
               end
               OP_GET: begin
                  if (scan_status.hit && scan_status.hit_live) begin
                     rsp_value_in = hit_value;
                  end else begin
                     rsp_status_in = STAT_MISS;
                  end
               end
               OP_ERASE: begin
                  mem_we    = scan_status.hit;
                  mem_waddr = hit_idx;
                  if (!(scan_status.hit && scan_status.hit_live)) rsp_status_in = STAT_MISS;
               end
               default: begin
                  rsp_status_in = STAT_OK;
               end
            endcase
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end else begin
               rsp_status_in = rsp_status_ff;
               rsp_value_in  = rsp_value_ff;
            end
         end
         default: begin
            rd_addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rd_addr_ff    <= '0;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         time_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_addr_ff    <= rd_addr_in;
         issue_done_ff <= issue_done_in;
         chk_valid_ff  <= chk_valid_in;
         time_ff       <= time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      if (accept) begin
         op_ff    <= op_type'(req_operation);
         key_ff   <= req_lookup_key;
         value_ff <= req_store_value;
         life_ff  <= req_lifetime;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_scan_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && op_type'(req_operation) != OP_TICK) |=> state_ff == ST_SCAN)
      else $error("lookup beat did not start a scan");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (accept && op_type'(req_operation) == OP_TICK && time_ff != {TIME_W{1'b1}})
      |=> time_ff == $past(time_ff) + TIME_W'(1))
      else $error("tick did not advance time");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_SCAN) |-> !mem_we)
      else $error("slot write outside clear or finish");
`endif

endmodule

`default_nettype wire

/* test/ttl_key_value_table_tb.sv */
// Testbench for ttl_key_value_table: a directed table of beats, then random bursts of
// fill, mixed, tick, erase and noise beats, checked against a model of the table.
// Depends on ttl_pkg and ttl_key_value_table.
`default_nettype none

module ttl_key_value_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ttl_pkg::*;

   localparam int SLOTS        = ENTRIES_DEFAULT;
   localparam int RANDOM_BEATS = 1750;
   localparam int POOL_SIZE    = 96;
   localparam int IDLE_PCT     = 28;
   localparam int MAX_REPORTS  = 10;
   localparam int TAIL_CYCLES  = 4 * SLOTS;
   localparam int SCRIPT_LEN   = 24;

   typedef struct {
      status_type  status;
      logic [31:0] value;
   } answer_type;

   typedef struct {
      op_type      op;
      logic [31:0] key;
      logic [31:0] value;
      logic [23:0] life;
      bit          typed;
      status_type  status;
      logic [31:0] read;
   } script_row_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation   = OP_TICK;
   logic [31:0]        req_lookup_key  = '0;
   logic signed [31:0] req_store_value = '0;
   logic [23:0]        req_lifetime    = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_value;

   bit          entry_valid [SLOTS] = '{default: 1'b0};
   logic [31:0] entry_key [SLOTS];
   logic [31:0] entry_value [SLOTS];
   logic [31:0] entry_expiry [SLOTS];
   logic [31:0] time_count = '0;

   answer_type     answers_due [$];
   script_row_type script [SCRIPT_LEN];
   logic [31:0]    key_pool [POOL_SIZE];
   int             beats_sent = 0;
   int             mismatches = 0;
   bit             calm       = 1'b0;

   ttl_key_value_table #(
      .ENTRIES(SLOTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_lookup_key (req_lookup_key),
      .req_store_value(req_store_value),
      .req_lifetime   (req_lifetime),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit entry_stale(int s);
      return time_count > entry_expiry[s];
   endfunction

   function automatic int slot_of_key(logic [31:0] key);
      for (int i = 0; i < SLOTS; i++) begin
         if (entry_valid[i] && entry_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic int first_open_slot();
      for (int i = 0; i < SLOTS; i++) begin
         if (!entry_valid[i] || entry_stale(i)) return i;
      end
      return -1;
   endfunction

   function automatic answer_type apply_operation(op_type op, logic [31:0] key,
                                                  logic [31:0] val, logic [23:0] life);
      answer_type  ans;
      int          s;
      logic [32:0] sum;
      ans.status = STAT_OK;
      ans.value  = '0;
      case (op)
         OP_PUT: begin
            s = slot_of_key(key);
            if (s < 0) s = first_open_slot();
            if (s < 0) begin
               ans.status = STAT_FULL;
            end else begin
               sum = {1'b0, time_count} + {9'd0, life};
               entry_valid[s]  = 1'b1;
               entry_key[s]    = key;
               entry_value[s]  = val;
               entry_expiry[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
         end
         OP_GET: begin
            s = slot_of_key(key);
            if (s >= 0 && !entry_stale(s)) ans.value = entry_value[s];
            else ans.status = STAT_MISS;
         end
         OP_ERASE: begin
            s = slot_of_key(key);
            if (s < 0 || entry_stale(s)) ans.status = STAT_MISS;
            if (s >= 0) entry_valid[s] = 1'b0;
         end
         default: begin
            if (time_count != 32'hFFFF_FFFF) time_count++;
         end
      endcase
      return ans;
   endfunction

   function automatic logic [23:0] pick_life();
      int r;
      r = $urandom_range(9);
      if (r < 4) return 24'($urandom_range(6));
      if (r < 7) return 24'($urandom_range(200, 7));
      return 24'($urandom);
   endfunction

   function automatic logic [31:0] pool_key();
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   task automatic send_beat(op_type op, logic [31:0] key, logic [31:0] val,
                            logic [23:0] life, bit typed = 1'b0,
                            status_type st = STAT_OK, logic [31:0] rd = '0);
      answer_type predicted;
      while ($urandom_range(99) < (calm ? 0 : IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_lookup_key  <= key;
      req_store_value <= val;
      req_lifetime    <= life;
      do @(posedge clock); while (!req_ready);
      predicted = apply_operation(op, key, val, life);
      if (typed) begin
         predicted.status = st;
         predicted.value  = rd;
      end
      answers_due.push_back(predicted);
      beats_sent++;
   endtask

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= (calm ? 0 : IDLE_PCT));
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            note_mismatch("unexpected beat", '0, {30'd0, rsp_status});
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", {30'd0, want.status}, {30'd0, rsp_status});
            if (rsp_read_value !== want.value)
               note_mismatch("read_value", want.value, rsp_read_value);
         end
      end
   end

   initial begin
      int burst;
      int r;
      op_type op;
      script = '{
         '{OP_GET,   32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_MISS, 32'h0},
         '{OP_ERASE, 32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_MISS, 32'h0},
         '{OP_TICK,  32'h0000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, STAT_OK,   32'h0},
         '{OP_PUT,   32'h0000_0000, 32'h8000_0000, 24'hFF_FFFF, 1'b1, STAT_OK,   32'h0},
         '{OP_PUT,   32'hFFFF_FFFF, 32'h7FFF_FFFF, 24'h00_0000, 1'b1, STAT_OK,   32'h0},
         '{OP_GET,   32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_OK,
           32'h8000_0000},
         '{OP_GET,   32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_OK,
           32'h7FFF_FFFF},
         '{OP_TICK,  32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_OK,   32'h0},
         '{OP_GET,   32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_MISS, 32'h0},
         '{OP_PUT,   32'hFFFF_FFFF, 32'h0000_1234, 24'h00_0005, 1'b1, STAT_OK,   32'h0},
         '{OP_GET,   32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b0, STAT_OK,   32'h0},
         '{OP_ERASE, 32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_OK,   32'h0},
         '{OP_ERASE, 32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_MISS, 32'h0},
         '{OP_PUT,   32'h5555_5555, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, STAT_OK,   32'h0},
         '{OP_TICK,  32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_OK,   32'h0},
         '{OP_ERASE, 32'h5555_5555, 32'h0000_0000, 24'h00_0000, 1'b1, STAT_MISS, 32'h0},
         '{OP_PUT,   32'hAAAA_AAAA, 32'h0000_0000, 24'h00_0001, 1'b1, STAT_OK,   32'h0},
         '{OP_GET,   32'hAAAA_AAAA, 32'h0000_0000, 24'h00_0000, 1'b0, STAT_OK,   32'h0},
         '{OP_PUT,   32'h0000_0000, 32'h0000_0005, 24'h80_0000, 1'b0, STAT_OK,   32'h0},
         '{OP_GET,   32'h0000_0000, 32'hAAAA_AAAA, 24'h55_5555, 1'b0, STAT_OK,   32'h0},
         '{OP_TICK,  32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b0, STAT_OK,   32'h0},
         '{OP_TICK,  32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b0, STAT_OK,   32'h0},
         '{OP_GET,   32'hAAAA_AAAA, 32'h0000_0000, 24'h00_0000, 1'b0, STAT_OK,   32'h0},
         '{OP_PUT,   32'h1234_5678, 32'h8765_4321, 24'h55_5555, 1'b0, STAT_OK,   32'h0}
      };
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_beat(script[i].op, script[i].key, script[i].value, script[i].life,
                   script[i].typed, script[i].status, script[i].read);

      while (beats_sent < SCRIPT_LEN + RANDOM_BEATS) begin
         calm  = (beats_sent >= 700 && beats_sent < 950);
         burst = $urandom_range(9);
         if (burst < 2) begin
            repeat ($urandom_range(80, 40)) send_beat(OP_PUT, pool_key(), $urandom, pick_life());
         end else if (burst < 6) begin
            repeat (24) begin
               r  = $urandom_range(9);
               op = (r < 4) ? OP_PUT : (r < 7) ? OP_GET : (r < 9) ? OP_ERASE : OP_TICK;
               send_beat(op, pool_key(), $urandom, pick_life());
            end
         end else if (burst < 7) begin
            repeat ($urandom_range(12, 1)) send_beat(OP_TICK, $urandom, $urandom, pick_life());
         end else if (burst < 8) begin
            repeat (30) send_beat(OP_ERASE, pool_key(), $urandom, pick_life());
         end else begin
            repeat (10) send_beat(op_type'($urandom_range(3)), $urandom, $urandom, 24'($urandom));
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ttl_key_value_table] OK");
      end else begin
         $display("[ttl_key_value_table] ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("[ttl_key_value_table] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
